@@ rtl/gbp_pkg.sv @@
// Shared types and constants for the gshare branch predictor core.
// No dependencies; used by gbp_table and gshare_branch_predictor_core.
package gbp_pkg;

    // Two-bit saturating direction counter
    typedef logic [1:0] t_ctr;

    localparam t_ctr CTR_MIN       = 2'd0;
    localparam t_ctr CTR_MAX       = 2'd3;
    localparam t_ctr CTR_TAKEN_MIN = 2'd2;

    localparam int HIST_LEN_W = 4;
    localparam logic [HIST_LEN_W-1:0] HIST_LEN_RESET = 4'd10;

    // Stream payload layout
    localparam int ADDR_W      = 32;
    localparam int IN_TDATA_W  = 40;   // addr(32) + taken(1), padded to bytes
    localparam int REPORT_W    = 32;   // width of each reported count
    localparam int OUT_TDATA_W = 168;  // 2 flags + 5 counts of 32, padded
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 - 5 * REPORT_W;

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } t_state;

endpackage

@@ rtl/gbp_table.sv @@
// Pattern history table: single-write, single-read memory of 2-bit counters
// with a clearing pass after reset. Depends on gbp_pkg.
module gbp_table #(
    parameter int INDEX_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [INDEX_BITS-1:0] i_rd_addr,
    output gbp_pkg::t_ctr         o_rd_data,
    input  logic                  i_wr_en,
    input  logic [INDEX_BITS-1:0] i_wr_addr,
    input  gbp_pkg::t_ctr         i_wr_data,
    output logic                  o_busy
);

    localparam int DEPTH = 1 << INDEX_BITS;

    gbp_pkg::t_ctr r_mem [DEPTH];
    gbp_pkg::t_ctr r_rd_data;

    logic                  r_clr_busy, n_clr_busy;
    logic [INDEX_BITS-1:0] r_clr_addr, n_clr_addr;

    logic                  wen;
    logic [INDEX_BITS-1:0] waddr;
    gbp_pkg::t_ctr         wdata;

    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_addr = r_clr_addr;
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + INDEX_BITS'(1);
            if (&r_clr_addr) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clr_busy <= n_clr_busy;
            r_clr_addr <= n_clr_addr;
        end
    end

    // clearing pass owns the write port until it finishes
    assign wen   = r_clr_busy | i_wr_en;
    assign waddr = r_clr_busy ? r_clr_addr : i_wr_addr;
    assign wdata = r_clr_busy ? gbp_pkg::CTR_MIN : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_mem[waddr] <= wdata;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

@@ rtl/gshare_branch_predictor_core.sv @@
// gshare branch predictor core: top level with stream ports and event counts.
// Depends on gbp_pkg and gbp_table.
//
// A branch is accepted in S_IDLE, where the counter at (history XOR
// address) is read; S_UPDATE then predicts, writes the counter back,
// shifts the history and loads the result once the result register is
// free, so no new branch is accepted until that update is done, set by the
// read-modify-write on the single-write counter table. The result register
// frees the input side once loaded. After reset the table is cleared one
// entry a cycle, 2^INDEX_BITS entries (1024 by default), during which no
// branch is accepted; history length writes are taken at any time.
module gshare_branch_predictor_core #(
    parameter int INDEX_BITS = 10,
    parameter int COUNT_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config: history_length
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gbp_pkg::HIST_LEN_W-1:0]   i_cfg_data,
    // tdata: branch_address[31:0], taken[32], zero pad
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [gbp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tdata: predicted_taken[0], mispredicted[1], right_taken_count[33:2],
    // right_not_taken_count[65:34], wrong_taken_count[97:66],
    // wrong_not_taken_count[129:98], total_branches[161:130], zero pad
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [gbp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    gbp_pkg::t_state r_state, n_state;

    logic [gbp_pkg::HIST_LEN_W-1:0] r_hist_len;
    logic [INDEX_BITS-1:0]          r_hist, n_hist;
    logic [INDEX_BITS-1:0]          r_idx;
    logic                           r_taken;
    logic [INDEX_BITS-1:0]          hist_mask;
    logic [INDEX_BITS-1:0]          idx;

    logic r_out_valid, n_out_valid;
    logic r_out_pred, n_out_pred;
    logic r_out_misp, n_out_misp;

    logic [COUNT_BITS-1:0] r_cnt_rt, n_cnt_rt;
    logic [COUNT_BITS-1:0] r_cnt_rnt, n_cnt_rnt;
    logic [COUNT_BITS-1:0] r_cnt_wt, n_cnt_wt;
    logic [COUNT_BITS-1:0] r_cnt_wnt, n_cnt_wnt;
    logic [COUNT_BITS-1:0] r_cnt_total, n_cnt_total;

    logic          in_fire;
    logic          tbl_busy;
    logic          tbl_wr_en;
    gbp_pkg::t_ctr ctr, ctr_next;
    logic          pred;

    gbp_table #(
        .INDEX_BITS (INDEX_BITS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire),
        .i_rd_addr (idx),
        .o_rd_data (ctr),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (ctr_next),
        .o_busy    (tbl_busy)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == gbp_pkg::S_IDLE) && !tbl_busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign idx           = r_hist ^ s_axis_tdata[INDEX_BITS-1:0];

    // lengths past INDEX_BITS simply keep every bit
    always_comb begin
        for (int i = 0; i < INDEX_BITS; i++) begin
            hist_mask[i] = 32'(i) < 32'(r_hist_len);
        end
    end

    assign pred = ctr >= gbp_pkg::CTR_TAKEN_MIN;

    always_comb begin
        ctr_next = ctr;
        if (r_taken) begin
            if (ctr != gbp_pkg::CTR_MAX) begin
                ctr_next = ctr + 2'd1;
            end
        end else begin
            if (ctr != gbp_pkg::CTR_MIN) begin
                ctr_next = ctr - 2'd1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_hist      = r_hist;
        n_out_valid = r_out_valid;
        n_out_pred  = r_out_pred;
        n_out_misp  = r_out_misp;
        n_cnt_rt    = r_cnt_rt;
        n_cnt_rnt   = r_cnt_rnt;
        n_cnt_wt    = r_cnt_wt;
        n_cnt_wnt   = r_cnt_wnt;
        n_cnt_total = r_cnt_total;
        tbl_wr_en   = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            gbp_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state = gbp_pkg::S_UPDATE;
                end
            end
            gbp_pkg::S_UPDATE: begin
                // wait until the result register is free
                if (!r_out_valid || m_axis_tready) begin
                    tbl_wr_en   = 1'b1;
                    n_state     = gbp_pkg::S_IDLE;
                    n_out_valid = 1'b1;
                    n_out_pred  = pred;
                    n_out_misp  = pred != r_taken;
                    n_hist      = INDEX_BITS'({r_hist, r_taken}) & hist_mask;
                    if (pred && r_taken && !(&r_cnt_rt)) begin
                        n_cnt_rt = r_cnt_rt + COUNT_BITS'(1);
                    end
                    if (!pred && !r_taken && !(&r_cnt_rnt)) begin
                        n_cnt_rnt = r_cnt_rnt + COUNT_BITS'(1);
                    end
                    if (!pred && r_taken && !(&r_cnt_wt)) begin
                        n_cnt_wt = r_cnt_wt + COUNT_BITS'(1);
                    end
                    if (pred && !r_taken && !(&r_cnt_wnt)) begin
                        n_cnt_wnt = r_cnt_wnt + COUNT_BITS'(1);
                    end
                    if (!(&r_cnt_total)) begin
                        n_cnt_total = r_cnt_total + COUNT_BITS'(1);
                    end
                end
            end
            default: begin
                n_state = gbp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gbp_pkg::S_IDLE;
            r_hist_len  <= gbp_pkg::HIST_LEN_RESET;
            r_hist      <= '0;
            r_out_valid <= 1'b0;
            r_cnt_rt    <= '0;
            r_cnt_rnt   <= '0;
            r_cnt_wt    <= '0;
            r_cnt_wnt   <= '0;
            r_cnt_total <= '0;
        end else begin
            r_state     <= n_state;
            r_hist      <= n_hist;
            r_out_valid <= n_out_valid;
            r_cnt_rt    <= n_cnt_rt;
            r_cnt_rnt   <= n_cnt_rnt;
            r_cnt_wt    <= n_cnt_wt;
            r_cnt_wnt   <= n_cnt_wnt;
            r_cnt_total <= n_cnt_total;
            if (i_cfg_valid && o_cfg_ready) begin
                r_hist_len <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pred <= n_out_pred;
        r_out_misp <= n_out_misp;
        if (in_fire) begin
            r_idx   <= idx;
            r_taken <= s_axis_tdata[gbp_pkg::ADDR_W];
        end
    end

    // counts only change on an update, which waits for the result to drain
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {
        {gbp_pkg::OUT_PAD_W{1'b0}},
        gbp_pkg::REPORT_W'(r_cnt_total),
        gbp_pkg::REPORT_W'(r_cnt_wnt),
        gbp_pkg::REPORT_W'(r_cnt_wt),
        gbp_pkg::REPORT_W'(r_cnt_rnt),
        gbp_pkg::REPORT_W'(r_cnt_rt),
        r_out_misp,
        r_out_pred
    };

endmodule
